/* sv/assert_macros.svh */
// Assertion macros shared by the edge table builder.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Implication checked in the clock cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

/* sv/meab_pkg.sv */
// Shared types and constants of the mesh edge table builder.
// Depends on nothing.
package meab_pkg;
	localparam int unsigned VtxW    = 10;
	localparam int unsigned FaceW   = 8;
	localparam int unsigned MaxEdges = 256;
	localparam int unsigned SlotW   = $clog2(MaxEdges);
	localparam int unsigned CountW  = SlotW + 1;
	localparam int unsigned OthW    = 9;
	localparam logic [OthW-1:0] NoFace = 9'd256;

	localparam logic [1:0] StNew    = 2'd0;
	localparam logic [1:0] StMatch  = 2'd1;
	localparam logic [1:0] StFull   = 2'd2;
	localparam logic [1:0] StShared = 2'd3;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);

	// One edge job handed from the front end to the table engine.
	typedef struct packed {
		logic             clear;
		logic [VtxW-1:0]  v0;
		logic [VtxW-1:0]  v1;
		logic [FaceW-1:0] face;
		logic             final_result;
	} job_t;
endpackage

/* sv/meab_front.sv */
// Front end: tracks the open face and turns corners into edge jobs.
// Depends on meab_pkg.
module meab_front import meab_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic [VtxW-1:0]  vertex_index,
	input  logic [FaceW-1:0] face_index,
	input  logic             last_of_face,
	output logic             job_valid,
	input  logic             job_stall,
	output job_t             job
);
	logic            inside_q;
	logic [VtxW-1:0] start_q;
	logic [VtxW-1:0] prior_q;
	// A held second job (closing edge) waiting after the first one went out.
	logic            pend_q;
	job_t            pend_job_q;
	job_t            first_job;
	job_t            close_job;
	logic            take;

	always_comb begin
		first_job = '{clear: mode, v0: prior_q, v1: vertex_index, face: face_index,
			final_result: !last_of_face};
		close_job = '{clear: 1'b0, v0: vertex_index,
			v1: inside_q ? start_q : vertex_index, face: face_index, final_result: 1'b1};
	end

	assign in_stall = pend_q || job_stall;
	assign take = in_valid && !in_stall;

	always_comb begin
		job_valid = 1'b0;
		job = first_job;
		if (pend_q) begin
			job_valid = 1'b1;
			job = pend_job_q;
		end else if (in_valid) begin
			if (mode) begin
				job_valid = 1'b1;
			end else if (inside_q) begin
				job_valid = 1'b1;
			end else if (last_of_face) begin
				job_valid = 1'b1;
				job = close_job;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			pend_q <= 1'b0;
			start_q <= '0;
			prior_q <= '0;
		end else begin
			if (pend_q && !job_stall) pend_q <= 1'b0;
			if (take) begin
				if (mode) begin
					inside_q <= 1'b0;
				end else begin
					if (!inside_q) start_q <= vertex_index;
					prior_q <= vertex_index;
					inside_q <= !last_of_face;
					if (inside_q && last_of_face) begin
						pend_q <= 1'b1;
						pend_job_q <= close_job;
					end
				end
			end
		end
	end
endmodule

/* sv/meab_queue.sv */
// Short request queue between the front end and the table engine.
// Depends on meab_pkg.
module meab_queue import meab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_take,
	output job_t rd_job
);
	job_t           mem_q [QDepth];
	logic [QPtrW:0] wp_q;
	logic [QPtrW:0] rp_q;
	logic           full;

	assign full = (wp_q[QPtrW] != rp_q[QPtrW]) && (wp_q[QPtrW-1:0] == rp_q[QPtrW-1:0]);
	assign wr_stall = full;
	assign rd_valid = wp_q != rp_q;
	assign rd_job = mem_q[rp_q[QPtrW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_valid && !full) mem_q[wp_q[QPtrW-1:0]] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && !full) wp_q <= wp_q + 1'b1;
			if (rd_take && rd_valid) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

/* sv/meab_back.sv */
// Table engine: scans the edge table entry by entry and emits results.
// Depends on meab_pkg.
module meab_back import meab_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_take,
	input  job_t              job,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SlotW-1:0]  edge_slot,
	output logic [VtxW-1:0]   end_a,
	output logic [VtxW-1:0]   end_b,
	output logic [FaceW-1:0]  owner_face,
	output logic [OthW-1:0]   other_face,
	output logic [1:0]        status,
	output logic              final_result,
	output logic              busy
);
	localparam logic [1:0] SIdle = 2'd0;
	localparam logic [1:0] SRead = 2'd1;
	localparam logic [1:0] SCmp  = 2'd2;
	localparam logic [1:0] SOut  = 2'd3;

	logic [VtxW-1:0]  ea_mem [MaxEdges];
	logic [VtxW-1:0]  eb_mem [MaxEdges];
	logic [FaceW-1:0] own_mem [MaxEdges];
	logic [OthW-1:0]  oth_mem [MaxEdges];

	logic [1:0]        st_q;
	logic [CountW-1:0] total_q;
	logic [CountW-1:0] idx_q;
	job_t              cur_q;
	logic [VtxW-1:0]   rd_a_q;
	logic [VtxW-1:0]   rd_b_q;
	logic [FaceW-1:0]  rd_own_q;
	logic [OthW-1:0]   rd_oth_q;
	logic              hit;
	logic              wr_en;
	logic [SlotW-1:0]  wr_slot;
	logic [VtxW-1:0]   wr_a;
	logic [VtxW-1:0]   wr_b;
	logic [FaceW-1:0]  wr_own;
	logic [OthW-1:0]   wr_oth;
	logic              wr_all;

	assign hit = (rd_a_q == cur_q.v0 && rd_b_q == cur_q.v1) ||
		(rd_a_q == cur_q.v1 && rd_b_q == cur_q.v0);
	assign job_take = (st_q == SIdle) && job_valid;
	assign out_valid = st_q == SOut;
	assign busy = st_q != SIdle;

	always_comb begin
		wr_en = 1'b0;
		wr_all = 1'b0;
		wr_slot = idx_q[SlotW-1:0];
		wr_a = cur_q.v0;
		wr_b = cur_q.v1;
		wr_own = cur_q.face;
		wr_oth = {1'b0, cur_q.face};
		if (st_q == SCmp && hit && rd_oth_q == NoFace) begin
			wr_en = 1'b1;
		end else if (st_q == SRead && idx_q >= total_q && !total_q[CountW-1]) begin
			wr_en = 1'b1;
			wr_all = 1'b1;
			wr_slot = total_q[SlotW-1:0];
			wr_oth = NoFace;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			oth_mem[wr_slot] <= wr_oth;
			if (wr_all) begin
				ea_mem[wr_slot] <= wr_a;
				eb_mem[wr_slot] <= wr_b;
				own_mem[wr_slot] <= wr_own;
			end
		end
		rd_a_q <= ea_mem[idx_q[SlotW-1:0]];
		rd_b_q <= eb_mem[idx_q[SlotW-1:0]];
		rd_own_q <= own_mem[idx_q[SlotW-1:0]];
		rd_oth_q <= oth_mem[idx_q[SlotW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SIdle;
			total_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			edge_slot <= '0;
			end_a <= '0;
			end_b <= '0;
			owner_face <= '0;
			other_face <= '0;
			status <= StNew;
			final_result <= 1'b0;
		end else begin
			unique case (st_q)
				SIdle: begin
					if (job_valid) begin
						cur_q <= job;
						idx_q <= '0;
						if (job.clear) total_q <= '0;
						else st_q <= SRead;
					end
				end
				SRead: begin
					// The read address is presented; end of scan means a miss.
					if (idx_q >= total_q) begin
						end_a <= cur_q.v0;
						end_b <= cur_q.v1;
						owner_face <= cur_q.face;
						other_face <= NoFace;
						final_result <= cur_q.final_result;
						if (total_q[CountW-1]) begin
							status <= StFull;
							edge_slot <= '0;
						end else begin
							status <= StNew;
							edge_slot <= total_q[SlotW-1:0];
							total_q <= total_q + 1'b1;
						end
						st_q <= SOut;
					end else begin
						st_q <= SCmp;
					end
				end
				SCmp: begin
					if (hit) begin
						edge_slot <= idx_q[SlotW-1:0];
						end_a <= rd_a_q;
						end_b <= rd_b_q;
						owner_face <= rd_own_q;
						final_result <= cur_q.final_result;
						if (rd_oth_q == NoFace) begin
							other_face <= {1'b0, cur_q.face};
							status <= StMatch;
						end else begin
							other_face <= rd_oth_q;
							status <= StShared;
						end
						st_q <= SOut;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= SRead;
					end
				end
				SOut: begin
					if (!out_stall) st_q <= SIdle;
				end
				default: st_q <= SIdle;
			endcase
		end
	end
endmodule

/* sv/mesh_edge_adjacency_build.sv */
// Top level of the mesh edge table builder.
// Depends on meab_pkg, meab_front, meab_queue, meab_back and assert_macros.svh.
//
// Usage: face corners enter on the input channel (in_valid / in_stall) in
// winding order. A mode of 1 requests that the edge table be emptied and
// produces no result. Every corner but the first of a face produces one
// edge result; the closing corner produces a second one for the edge back
// to the face's first vertex. Results leave on the output channel
// (out_valid / out_stall), final_result marking the last one of a request.
// The front end classifies corners into edge jobs that wait in a four-entry
// queue; the back end searches the table one entry at a time (a registered
// read and a compare) and takes a new job only when idle. The front end may
// run ahead by up to the queue depth. A stalled result is held in the output
// registers and the back end waits. After reset the table is empty and no
// face is open; table contents need no clearing pass because only entries
// below the fill count are read.
module mesh_edge_adjacency_build import meab_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [VtxW-1:0]   vertex_index,
	input  logic [FaceW-1:0]  face_index,
	input  logic              last_of_face,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SlotW-1:0]  edge_slot,
	output logic [VtxW-1:0]   end_a,
	output logic [VtxW-1:0]   end_b,
	output logic [FaceW-1:0]  owner_face,
	output logic [OthW-1:0]   other_face,
	output logic [1:0]        status,
	output logic              final_result
);
`include "assert_macros.svh"

	logic fj_valid;
	logic fj_stall;
	job_t fj;
	logic bj_valid;
	logic bj_take;
	job_t bj;
	logic busy;

	meab_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .vertex_index, .face_index,
		.last_of_face, .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
	);

	meab_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_job(fj),
		.rd_valid(bj_valid), .rd_take(bj_take), .rd_job(bj)
	);

	meab_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_take(bj_take), .job(bj),
		.out_valid, .out_stall, .edge_slot, .end_a, .end_b, .owner_face,
		.other_face, .status, .final_result, .busy
	);

	// A new edge never carries a second face yet.
	`CHK_IMPLY(a_new_no_other, clk, arst_n, out_valid && status == StNew,
		other_face == NoFace)
	// A dropped edge always reports slot zero.
	`CHK_IMPLY(a_full_slot, clk, arst_n, out_valid && status == StFull, edge_slot == '0)
	// A taken job other than a clear leaves the engine busy.
	`CHK_NEXT(a_take_busy, clk, arst_n, bj_take && !bj.clear, busy)
endmodule
